FILE: hw/rtl/three_button_debounce_navigation_macros.svh
// Assertion helpers shared by the RTL. Each expects clk_i and rst_ni in scope.
`ifndef THREE_BUTTON_DEBOUNCE_NAVIGATION_MACROS_SVH
`define THREE_BUTTON_DEBOUNCE_NAVIGATION_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TBDN_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tbdn: implication check failed");

// Next-cycle implication, checked outside reset.
`define TBDN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tbdn: next-cycle check failed");

`endif

FILE: hw/rtl/tbdn_pkg.sv
package tbdn_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DEB_W   = 16;
  localparam int unsigned NUM_BTN = 3;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  // Bit positions of the buttons in the level vectors.
  localparam int unsigned BTN_LEFT   = 0;
  localparam int unsigned BTN_SELECT = 1;
  localparam int unsigned BTN_RIGHT  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_TIME       = 8'd0,
    REG_DOUBLE_PRESS_WINDOW = 8'd1,
    REG_PANEL_ROTATED       = 8'd2,
    REG_SWAP_SETTING        = 8'd3,
    REG_NAVIGATION_BLOCKED  = 8'd4
  } tbdn_reg_e;

  typedef enum logic [1:0] {
    PWR_NONE = 2'd0,
    PWR_ON   = 2'd1,
    PWR_OFF  = 2'd2
  } tbdn_power_e;

  // Per-button status: the level held now and the level after this request.
  typedef struct packed {
    logic level;
    logic level_next;
  } tbdn_btn_t;

endpackage

FILE: hw/rtl/tbdn_debounce.sv
module tbdn_debounce (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          advance_i,
  input  logic [tbdn_pkg::TIME_W-1:0]   now_ms_i,
  input  logic                          raw_i,
  input  logic [tbdn_pkg::DEB_W-1:0]    debounce_time_i,
  output tbdn_pkg::tbdn_btn_t           status_o
);
  import tbdn_pkg::*;

  logic              last_raw_q, last_raw_d;
  logic [TIME_W-1:0] change_time_q, change_time_d;
  logic              stable_q, stable_d;
  logic              raw_changed;
  logic [TIME_W-1:0] held_ms;

  always_comb begin
    raw_changed   = raw_i != last_raw_q;
    last_raw_d    = raw_i;
    change_time_d = raw_changed ? now_ms_i : change_time_q;
    // A fresh change has held for zero milliseconds.
    held_ms       = raw_changed ? '0 : (now_ms_i - change_time_q);
    stable_d      = stable_q;
    if ((raw_i != stable_q) && (held_ms >= {{(TIME_W-DEB_W){1'b0}}, debounce_time_i})) begin
      stable_d = raw_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q    <= 1'b0;
      change_time_q <= '0;
      stable_q      <= 1'b0;
    end else if (advance_i) begin
      last_raw_q    <= last_raw_d;
      change_time_q <= change_time_d;
      stable_q      <= stable_d;
    end
  end

  assign status_o.level      = stable_q;
  assign status_o.level_next = stable_d;

endmodule

FILE: hw/rtl/three_button_debounce_navigation.sv
// Debounces the left, select and right buttons from timestamped ticks and turns their
// debounced rising edges into previous/next app, dismiss and display power requests.
// A tick request is captured in an input register, evaluated there and registered as
// a result when the result register can take it; one request can be accepted in every
// cycle while in_stall_o is low: all per-tick state (raw levels, change times, stable
// levels and the last select edge time) is read and updated in a single compute stage.
// The result register is separated from the input register, so an empty input register
// still takes a request while a finished result waits on out_stall_i. Configuration
// writes are always ready and must only be issued while no request is in flight.
`include "three_button_debounce_navigation_macros.svh"

module three_button_debounce_navigation (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tbdn_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tbdn_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Tick requests.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [tbdn_pkg::TIME_W-1:0]       now_ms_i,
  input  logic                              left_raw_i,
  input  logic                              select_raw_i,
  input  logic                              right_raw_i,
  input  logic                              display_off_i,
  // Results.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              left_stable_o,
  output logic                              select_stable_o,
  output logic                              right_stable_o,
  output logic                              buttons_changed_o,
  output logic                              want_previous_app_o,
  output logic                              want_next_app_o,
  output logic                              want_dismiss_o,
  output logic [1:0]                        display_power_request_o
);
  import tbdn_pkg::*;

  // Configuration registers.
  logic [DEB_W-1:0] debounce_q;
  logic [DEB_W-1:0] window_q;
  logic             rotated_q;
  logic             swap_q;
  logic             blocked_q;

  // Input stage.
  logic               s1_valid_q;
  logic [TIME_W-1:0]  s1_now_q;
  logic [NUM_BTN-1:0] s1_raw_q;
  logic               s1_doff_q;

  // Result stage.
  logic               out_valid_q;
  logic [NUM_BTN-1:0] out_stable_q;
  logic               out_changed_q;
  logic               out_prev_q;
  logic               out_next_q;
  logic               out_dismiss_q;
  tbdn_power_e        out_power_q;

  logic [TIME_W-1:0]  last_sel_q;

  logic               out_ready;
  logic               in_accept;
  logic               advance;

  tbdn_btn_t          btn [NUM_BTN];
  logic [NUM_BTN-1:0] stable_q;
  logic [NUM_BTN-1:0] stable_d;
  logic [NUM_BTN-1:0] edges;
  logic               swapped;
  logic [TIME_W-1:0]  sel_gap;
  logic               double_press;
  logic               prev_req;
  logic               next_req;
  logic               dismiss_req;
  tbdn_power_e        power_req;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEB_W'(50);
      window_q   <= DEB_W'(300);
      rotated_q  <= 1'b0;
      swap_q     <= 1'b0;
      blocked_q  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_DEBOUNCE_TIME:       debounce_q <= cfg_data_i[DEB_W-1:0];
        REG_DOUBLE_PRESS_WINDOW: window_q   <= cfg_data_i[DEB_W-1:0];
        REG_PANEL_ROTATED:       rotated_q  <= cfg_data_i[0];
        REG_SWAP_SETTING:        swap_q     <= cfg_data_i[0];
        REG_NAVIGATION_BLOCKED:  blocked_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Handshake: the input stage moves on whenever the result register is free or draining.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_now_q                <= now_ms_i;
      s1_raw_q[BTN_LEFT]      <= left_raw_i;
      s1_raw_q[BTN_SELECT]    <= select_raw_i;
      s1_raw_q[BTN_RIGHT]     <= right_raw_i;
      s1_doff_q               <= display_off_i;
    end
  end

  for (genvar g = 0; g < NUM_BTN; g++) begin : g_btn
    tbdn_debounce u_debounce (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .advance_i       (advance),
      .now_ms_i        (s1_now_q),
      .raw_i           (s1_raw_q[g]),
      .debounce_time_i (debounce_q),
      .status_o        (btn[g])
    );
  end

  always_comb begin
    for (int i = 0; i < NUM_BTN; i++) begin
      stable_q[i] = btn[i].level;
      stable_d[i] = btn[i].level_next;
    end
    edges        = stable_d & ~stable_q;
    swapped      = rotated_q ^ swap_q;
    sel_gap      = s1_now_q - last_sel_q;
    double_press = sel_gap <= {{(TIME_W-DEB_W){1'b0}}, window_q};

    prev_req    = 1'b0;
    next_req    = 1'b0;
    dismiss_req = edges[BTN_SELECT];
    power_req   = PWR_NONE;
    if (!blocked_q) begin
      if (edges[BTN_LEFT]) begin
        if (swapped) next_req = 1'b1;
        else prev_req = 1'b1;
      end
      if (edges[BTN_RIGHT]) begin
        if (swapped) prev_req = 1'b1;
        else next_req = 1'b1;
      end
      if (edges[BTN_SELECT] && double_press) begin
        power_req = s1_doff_q ? PWR_ON : PWR_OFF;
      end
    end
  end

  // The select edge time is recorded whether or not navigation is blocked.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_sel_q <= '0;
    end else if (advance && edges[BTN_SELECT]) begin
      last_sel_q <= s1_now_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_stable_q  <= stable_d;
      out_changed_q <= stable_d != stable_q;
      out_prev_q    <= prev_req;
      out_next_q    <= next_req;
      out_dismiss_q <= dismiss_req;
      out_power_q   <= power_req;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign left_stable_o           = out_stable_q[BTN_LEFT];
  assign select_stable_o         = out_stable_q[BTN_SELECT];
  assign right_stable_o          = out_stable_q[BTN_RIGHT];
  assign buttons_changed_o       = out_changed_q;
  assign want_previous_app_o     = out_prev_q;
  assign want_next_app_o         = out_next_q;
  assign want_dismiss_o          = out_dismiss_q;
  assign display_power_request_o = out_power_q;

  `TBDN_ASSERT_IMPL(a_power_needs_dismiss, out_valid_o && (out_power_q != PWR_NONE), want_dismiss_o)
  `TBDN_ASSERT_IMPL(a_dismiss_needs_select, out_valid_o && want_dismiss_o, select_stable_o && buttons_changed_o)
  `TBDN_ASSERT_IMPL(a_blocked_no_nav, out_valid_o && blocked_q, !want_previous_app_o && !want_next_app_o)
  `TBDN_ASSERT_NEXT(a_stall_holds_item, in_stall_o, s1_valid_q)

endmodule
